### hdl/apr_pkg.sv
// Shared types, constants and the decode function for the prologue relocator.
package apr_pkg;

    localparam int MAX_WINDOW_DEFAULT = 256;

    localparam logic [31:0] NOP_WORD   = 32'hD503201F;
    localparam logic [31:0] LDR_X16_L8 = 32'h58000050;
    localparam logic [31:0] BR_X16     = 32'hD61F0200;
    localparam logic [31:0] BLR_X16    = 32'hD63F0200;
    localparam logic [31:0] LDR_RT_X16 = 32'hF9400200;
    localparam logic [31:0] MOVZ_X16   = 32'hD2800010;
    localparam logic [31:0] MOVK_X16   = 32'hF2800010;

    localparam logic [1:0] CFG_SRC   = 2'd0;
    localparam logic [1:0] CFG_TRAMP = 2'd1;
    localparam logic [1:0] CFG_PATCH = 2'd2;
    localparam logic [1:0] CFG_LIMIT = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_UNSUPP = 2'd1;
    localparam logic [1:0] ST_BOUNDS = 2'd2;

    typedef enum logic [3:0] {
        K_UNKNOWN, K_COPY, K_B, K_BL, K_ADR, K_ADRP, K_LDRLIT, K_CB, K_TB
    } kind_t;

    // One decoded command for the back end.
    typedef struct packed {
        logic [31:0] instr;
        kind_t       kind;
        logic        abort;
        logic [1:0]  code;
        logic        relocate;
        logic        tail;
        logic [8:0]  src_off;
    } cmd_t;

    typedef enum logic [3:0] {
        S_IDLE, S_CALC, S_ONE, S_PAD, S_INV, S_LDR, S_BR, S_LITLO, S_LITHI,
        S_MOVZ, S_MOVK1, S_MOVK2, S_MOVK3, S_TBR, S_ABORT
    } seq_t;

    function automatic kind_t classify(input logic [31:0] w);
        kind_t k;
        k = K_UNKNOWN;
        if (w == NOP_WORD) k = K_COPY;
        else if ((w & 32'h7E000000) == 32'h34000000) k = K_CB;
        else if ((w & 32'h7E000000) == 32'h36000000) k = K_TB;
        else if ((w & 32'hFC000000) == 32'h14000000) k = K_B;
        else if ((w & 32'hFC000000) == 32'h94000000) k = K_BL;
        else if ((w & 32'hFC000000) == 32'hD4000000) k = K_COPY;
        else if ((w & 32'h9F000000) == 32'h10000000) k = K_ADR;
        else if ((w & 32'h9F000000) == 32'h90000000) k = K_ADRP;
        else if ((w & 32'hFF000000) == 32'h58000000) k = K_LDRLIT;
        else if ((w & 32'hFF800000) == 32'hD2800000) k = K_COPY;
        else if ((w & 32'hFF800000) == 32'hF2800000) k = K_COPY;
        return k;
    endfunction

endpackage

### hdl/apr_front.sv
// Front end: accept words, track source offset, classify and decide aborts.
module apr_front #(
    parameter int MAX_WINDOW = apr_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [31:0]       s_instruction,
    input  logic [8:0]        patch_bytes,
    input  logic [8:0]        limit_bytes,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output apr_pkg::cmd_t     cmd
);
    import apr_pkg::*;

    localparam int LW = $clog2(MAX_WINDOW + 1);
    localparam logic [LW+1:0] MAXW = (LW + 2)'(MAX_WINDOW);

    logic [8:0] src_off_reg, src_off_next;
    logic       full_reg;
    cmd_t       cmd_reg, cmd_new;
    logic       take;
    logic [LW+1:0] lim, need;

    assign s_ready   = !full_reg || cmd_ready;
    assign take      = s_valid && s_ready;
    assign cmd_valid = full_reg;
    assign cmd       = cmd_reg;

    // Classify the incoming word against the running offset.
    always_comb begin
        lim  = ((LW + 2)'(limit_bytes) < MAXW) ? (LW + 2)'(limit_bytes) : MAXW;
        need = (LW + 2)'(src_off_reg) + (LW + 2)'(4);
        cmd_new = '0;
        cmd_new.instr    = s_instruction;
        cmd_new.kind     = classify(s_instruction);
        cmd_new.src_off  = src_off_reg;
        src_off_next     = src_off_reg;
        if (src_off_reg < patch_bytes) begin
            if (need > lim) begin
                cmd_new.abort = 1'b1;
                cmd_new.code  = ST_BOUNDS;
                src_off_next  = '0;
            end else if (cmd_new.kind == K_UNKNOWN) begin
                cmd_new.abort = 1'b1;
                cmd_new.code  = ST_UNSUPP;
                src_off_next  = '0;
            end else begin
                cmd_new.relocate = 1'b1;
                src_off_next     = src_off_reg + 9'd4;
                cmd_new.tail     = (src_off_next >= patch_bytes);
                if (cmd_new.tail) src_off_next = '0;
            end
        end else begin
            cmd_new.tail = 1'b1;
            src_off_next = '0;
        end
    end

    // Hold the command until the back end takes it.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_off_reg <= '0;
            full_reg    <= 1'b0;
        end else begin
            if (take) begin
                src_off_reg <= src_off_next;
                full_reg    <= 1'b1;
            end else if (cmd_ready) begin
                full_reg <= 1'b0;
            end
        end
        if (take) cmd_reg <= cmd_new;
    end
endmodule

### hdl/apr_back.sv
// Back end: compute relocated words and serialise them onto the result channel.
module apr_back (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          cmd_valid,
    output logic          cmd_ready,
    input  apr_pkg::cmd_t cmd,
    input  logic [63:0]   source_address,
    input  logic [63:0]   trampoline_address,
    output logic          m_valid,
    input  logic          m_ready,
    output logic [31:0]   m_word,
    output logic [10:0]   m_byte_offset,
    output logic          m_run_last,
    output logic          m_finished,
    output logic [1:0]    m_status,
    output logic [8:0]    m_source_bytes,
    output logic [10:0]   m_trampoline_bytes
);
    import apr_pkg::*;

    seq_t        st_reg, st_next;
    cmd_t        c_reg;
    logic [10:0] toff_reg, toff_next;
    logic [63:0] pc_reg, tgt_reg, back_reg;
    logic [63:0] here_reg;
    logic [31:0] one_reg;

    // Output register
    logic        ov_reg;
    logic [31:0] ow_reg;
    logic [10:0] oo_reg, otb_reg;
    logic        orl_reg, ofin_reg;
    logic [1:0]  ost_reg;
    logic [8:0]  osb_reg;

    logic        ofree, emit;
    logic [31:0] ew;
    logic        erl, efin;
    logic [1:0]  est;
    logic [8:0]  esb;
    logic [10:0] etb;

    assign ofree = !ov_reg || m_ready;
    assign m_valid = ov_reg;
    assign m_word = ow_reg;
    assign m_byte_offset = oo_reg;
    assign m_run_last = orl_reg;
    assign m_finished = ofin_reg;
    assign m_status = ost_reg;
    assign m_source_bytes = osb_reg;
    assign m_trampoline_bytes = otb_reg;
    assign cmd_ready = (st_reg == S_IDLE);

    // Retarget arithmetic, registered in the calc state.
    logic [63:0] imm21, adr_tgt, d_calc, br_tgt, here;
    logic [31:0] one_calc;
    logic        fit_calc;
    always_comb begin
        here   = trampoline_address + 64'(toff_reg);
        imm21  = {{43{c_reg.instr[23]}}, c_reg.instr[23:5], c_reg.instr[30:29]};
        adr_tgt = '0;
        br_tgt  = '0;
        d_calc  = '0;
        one_calc = c_reg.instr;
        fit_calc = 1'b1;
        unique case (c_reg.kind)
            K_ADRP: begin
                adr_tgt = {pc_reg[63:12], 12'd0} + (imm21 << 12);
                d_calc  = (adr_tgt - {here_reg[63:12], 12'd0}) >> 12;
                one_calc = (c_reg.instr & 32'h9F00001F) | {1'b0, d_calc[1:0], 5'd0,
                           d_calc[20:2], 5'd0};
            end
            K_ADR: begin
                d_calc  = pc_reg + imm21 - here_reg;
                one_calc = (c_reg.instr & 32'h9F00001F) | {1'b0, d_calc[1:0], 5'd0,
                           d_calc[20:2], 5'd0};
            end
            K_LDRLIT, K_CB: begin
                br_tgt = pc_reg + {{43{c_reg.instr[23]}}, c_reg.instr[23:5], 2'd0};
                d_calc = br_tgt - here_reg;
                fit_calc = (d_calc[1:0] == 2'd0) &&
                           ((d_calc + 64'h100000) < 64'h200000);
                one_calc = {c_reg.instr[31:24], d_calc[20:2], c_reg.instr[4:0]};
            end
            K_TB: begin
                br_tgt = pc_reg + {{48{c_reg.instr[18]}}, c_reg.instr[18:5], 2'd0};
                d_calc = br_tgt - here_reg;
                fit_calc = (d_calc[1:0] == 2'd0) &&
                           ((d_calc + 64'h8000) < 64'h10000);
                one_calc = {c_reg.instr[31:19], d_calc[15:2], c_reg.instr[4:0]};
            end
            K_B, K_BL: begin
                br_tgt = pc_reg + {{36{c_reg.instr[25]}}, c_reg.instr[25:0], 2'd0};
                fit_calc = 1'b0;
            end
            default: ;
        endcase
    end

    // Next sequencer state.
    always_comb begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE: if (cmd_valid) begin
                if (cmd.abort) st_next = S_ABORT;
                else if (cmd.relocate) st_next = S_CALC;
                else st_next = S_MOVZ;
            end
            S_CALC: begin
                if (fit_calc && c_reg.kind != K_B && c_reg.kind != K_BL) st_next = S_ONE;
                else if (toff_reg[2]) st_next = S_PAD;
                else if (c_reg.kind == K_CB || c_reg.kind == K_TB) st_next = S_INV;
                else st_next = S_LDR;
            end
            default: if (ofree) begin
                unique case (st_reg)
                    S_ONE, S_LITHI: st_next = c_reg.tail ? S_MOVZ : S_IDLE;
                    S_PAD: st_next = (c_reg.kind == K_CB || c_reg.kind == K_TB) ?
                                     S_INV : S_LDR;
                    S_INV:   st_next = S_LDR;
                    S_LDR:   st_next = S_BR;
                    S_BR:    st_next = S_LITLO;
                    S_LITLO: st_next = S_LITHI;
                    S_MOVZ:  st_next = S_MOVK1;
                    S_MOVK1: st_next = S_MOVK2;
                    S_MOVK2: st_next = S_MOVK3;
                    S_MOVK3: st_next = S_TBR;
                    default: st_next = S_IDLE;
                endcase
            end
        endcase
    end

    // Word produced by the current state.
    always_comb begin
        emit = 1'b0;
        ew = NOP_WORD;
        erl = 1'b0;
        efin = 1'b0;
        est = ST_OK;
        esb = '0;
        etb = '0;
        toff_next = toff_reg;
        unique case (st_reg)
            S_IDLE, S_CALC: ;
            S_ONE: begin
                emit = 1'b1; ew = one_reg; erl = !c_reg.tail;
            end
            S_PAD: begin
                emit = 1'b1; ew = NOP_WORD;
            end
            S_INV: begin
                emit = 1'b1;
                ew = (c_reg.kind == K_TB) ?
                     {c_reg.instr[31:25], ~c_reg.instr[24], c_reg.instr[23:19],
                      14'd5, c_reg.instr[4:0]} :
                     {c_reg.instr[31:25], ~c_reg.instr[24], 19'd5, c_reg.instr[4:0]};
            end
            S_LDR: begin
                emit = 1'b1; ew = LDR_X16_L8;
            end
            S_BR: begin
                emit = 1'b1;
                // literal load goes through X16 into the original target register
                if (c_reg.kind == K_LDRLIT) ew = LDR_RT_X16 | {27'd0, c_reg.instr[4:0]};
                else ew = (c_reg.kind == K_BL) ? BLR_X16 : BR_X16;
            end
            S_LITLO: begin
                emit = 1'b1; ew = tgt_reg[31:0];
            end
            S_LITHI: begin
                emit = 1'b1; ew = tgt_reg[63:32]; erl = !c_reg.tail;
            end
            S_MOVZ: begin
                emit = 1'b1; ew = MOVZ_X16 | {11'd0, back_reg[15:0], 5'd0};
            end
            S_MOVK1: begin
                emit = 1'b1; ew = MOVK_X16 | {9'd0, 2'd1, back_reg[31:16], 5'd0};
            end
            S_MOVK2: begin
                emit = 1'b1; ew = MOVK_X16 | {9'd0, 2'd2, back_reg[47:32], 5'd0};
            end
            S_MOVK3: begin
                emit = 1'b1; ew = MOVK_X16 | {9'd0, 2'd3, back_reg[63:48], 5'd0};
            end
            S_TBR: begin
                emit = 1'b1; ew = BR_X16; erl = 1'b1; efin = 1'b1;
                esb = back_reg[8:0] - source_address[8:0];
                etb = toff_reg + 11'd4;
            end
            S_ABORT: begin
                emit = 1'b1; ew = '0; erl = 1'b1; efin = 1'b1; est = c_reg.code;
            end
            default: ;
        endcase
        if (emit && ofree) begin
            if (st_reg == S_TBR || st_reg == S_ABORT) toff_next = '0;
            else toff_next = toff_reg + 11'd4;
        end
    end

    // Advance sequencer and load the output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg   <= S_IDLE;
            toff_reg <= '0;
            ov_reg   <= 1'b0;
        end else begin
            st_reg   <= st_next;
            toff_reg <= toff_next;
            if (ofree) ov_reg <= emit;
        end
        if (st_reg == S_IDLE && cmd_valid) begin
            c_reg    <= cmd;
            pc_reg   <= source_address + 64'(cmd.src_off);
            here_reg <= here;
            back_reg <= source_address + 64'(cmd.src_off) +
                        (cmd.relocate ? 64'd4 : 64'd0);
        end
        if (st_reg == S_CALC) begin
            one_reg <= one_calc;
            tgt_reg <= br_tgt;
        end
        if (emit && ofree) begin
            ow_reg   <= ew;
            oo_reg   <= (st_reg == S_ABORT) ? 11'd0 : toff_reg;
            orl_reg  <= erl;
            ofin_reg <= efin;
            ost_reg  <= est;
            osb_reg  <= esb;
            otb_reg  <= etb;
        end
    end
endmodule

### hdl/arm64_prologue_relocator.sv
// Top level of the prologue relocator: config registers, front end and back end.
// Each source word is classified in the front end and queued for the back end,
// which emits at most one word per cycle: a copied or patched word passes through
// command load, retarget calculation and output, and the next command is taken
// only once the back end is idle again; a branch expansion passes through load and
// calculation and then up to six words, the return tail five more words, and a
// tail with nothing relocated is loaded and then emits its five words. Result
// stalls hold the sequencer. The back-end output sequencer sets the rate.
module arm64_prologue_relocator #(
    parameter int MAX_WINDOW = apr_pkg::MAX_WINDOW_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_instruction,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_word,
    output logic [10:0] m_byte_offset,
    output logic        m_run_last,
    output logic        m_finished,
    output logic [1:0]  m_status,
    output logic [8:0]  m_source_bytes,
    output logic [10:0] m_trampoline_bytes
);
    import apr_pkg::*;

    logic [63:0] src_addr_reg, tramp_addr_reg;
    logic [8:0]  patch_reg, limit_reg;
    logic        cmd_valid, cmd_ready;
    cmd_t        cmd;

    // Write configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_addr_reg   <= '0;
            tramp_addr_reg <= '0;
            patch_reg      <= 9'd4;
            limit_reg      <= 9'd256;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_SRC:   src_addr_reg   <= cfg_data;
                CFG_TRAMP: tramp_addr_reg <= cfg_data;
                CFG_PATCH: patch_reg      <= cfg_data[8:0];
                CFG_LIMIT: limit_reg      <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    apr_front #(.MAX_WINDOW(MAX_WINDOW)) u_front (
        .aclk, .aresetn, .s_valid, .s_ready, .s_instruction,
        .patch_bytes(patch_reg), .limit_bytes(limit_reg),
        .cmd_valid, .cmd_ready, .cmd
    );

    apr_back u_back (
        .aclk, .aresetn, .cmd_valid, .cmd_ready, .cmd,
        .source_address(src_addr_reg), .trampoline_address(tramp_addr_reg),
        .m_valid, .m_ready, .m_word, .m_byte_offset, .m_run_last,
        .m_finished, .m_status, .m_source_bytes, .m_trampoline_bytes
    );
endmodule
